[sv/csbe_pkg.sv]
package csbe_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned INDEX_W = 4;

  // Selected digit or field
  localparam logic [INDEX_W-1:0] IDX_HOUR_TENS = 4'd0;
  localparam logic [INDEX_W-1:0] IDX_HOUR_ONES = 4'd1;
  localparam logic [INDEX_W-1:0] IDX_MIN_TENS  = 4'd2;
  localparam logic [INDEX_W-1:0] IDX_MIN_ONES  = 4'd3;
  localparam logic [INDEX_W-1:0] IDX_SEC_TENS  = 4'd4;
  localparam logic [INDEX_W-1:0] IDX_SEC_ONES  = 4'd5;
  localparam logic [INDEX_W-1:0] IDX_DAY_A     = 4'd6;
  localparam logic [INDEX_W-1:0] IDX_DAY_B     = 4'd7;
  localparam logic [INDEX_W-1:0] IDX_MONTH_A   = 4'd8;
  localparam logic [INDEX_W-1:0] IDX_MONTH_B   = 4'd9;
  localparam logic [INDEX_W-1:0] IDX_YEAR      = 4'd10;
  localparam logic [INDEX_W-1:0] IDX_LAST      = IDX_YEAR;

  // Button bit positions in a poll
  localparam int unsigned BTN_SET  = 0;
  localparam int unsigned BTN_INC  = 1;
  localparam int unsigned BTN_DEC  = 2;
  localparam int unsigned BTN_SAVE = 3;

  localparam logic [YEAR_W-1:0] YEAR_MAX       = 14'd9999;
  localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 14'd2000;
  localparam logic [YEAR_W-1:0] YEAR_RESET     = 14'd2025;
  localparam logic [4:0]        HOUR_RESET     = 5'd12;

  // Address map: register word index
  localparam logic ADDR_MIN_YEAR = 1'b0;

  typedef struct packed {
    logic               editing;
    logic [INDEX_W-1:0] index;
    logic [4:0]         hours;
    logic [5:0]         minutes;
    logic [5:0]         seconds;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [YEAR_W-1:0]  year;
  } csbe_clock_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } csbe_queue_stat_t;

endpackage

[sv/csbe_field_step.sv]
module csbe_field_step (
  input  csbe_pkg::csbe_clock_t       cur,
  input  logic [3:0]                  prev_levels,
  input  logic [3:0]                  now_levels,
  input  logic [csbe_pkg::YEAR_W-1:0] min_year,
  output csbe_pkg::csbe_clock_t       nxt
);
  import csbe_pkg::*;

  logic [3:0]  fell;
  csbe_clock_t after_set;
  csbe_clock_t after_inc;
  csbe_clock_t after_dec;

  function automatic logic [5:0] wrap_add(input logic [5:0] v, input logic [5:0] by,
                                          input logic [5:0] modulus);
    logic [6:0] s;
    s = {1'b0, v} + {1'b0, by};
    if (s >= {1'b0, modulus}) begin
      s = s - {1'b0, modulus};
    end
    return s[5:0];
  endfunction

  function automatic logic [5:0] wrap_sub(input logic [5:0] v, input logic [5:0] by,
                                          input logic [5:0] top);
    return (v >= by) ? v - by : top;
  endfunction

  assign fell = prev_levels & ~now_levels;

  always_comb begin
    after_set = cur;
    if (fell[BTN_SET]) begin
      if (!cur.editing) begin
        after_set.editing = 1'b1;
        after_set.index   = IDX_HOUR_TENS;
      end else if (cur.index < IDX_LAST) begin
        after_set.index = cur.index + 4'd1;
      end else begin
        after_set.index = IDX_LAST;
      end
    end
  end

  always_comb begin
    logic [5:0] h6;
    h6 = {1'b0, after_set.hours};
    after_inc = after_set;
    if (fell[BTN_INC] && after_set.editing) begin
      case (after_set.index) inside
        IDX_HOUR_TENS: after_inc.hours = 5'(wrap_add(h6, 6'd10, 6'd24));
        IDX_HOUR_ONES: after_inc.hours = 5'(wrap_add(h6, 6'd1, 6'd24));
        IDX_MIN_TENS:  after_inc.minutes = wrap_add(after_set.minutes, 6'd10, 6'd60);
        IDX_MIN_ONES:  after_inc.minutes = wrap_add(after_set.minutes, 6'd1, 6'd60);
        IDX_SEC_TENS:  after_inc.seconds = wrap_add(after_set.seconds, 6'd10, 6'd60);
        IDX_SEC_ONES:  after_inc.seconds = wrap_add(after_set.seconds, 6'd1, 6'd60);
        IDX_DAY_A, IDX_DAY_B:
          after_inc.day = (after_set.day >= 5'd31) ? 5'd1 : after_set.day + 5'd1;
        IDX_MONTH_A, IDX_MONTH_B:
          after_inc.month = (after_set.month >= 4'd12) ? 4'd1 : after_set.month + 4'd1;
        IDX_YEAR:
          if (after_set.year < YEAR_MAX) after_inc.year = after_set.year + 14'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [5:0] h6;
    h6 = {1'b0, after_inc.hours};
    after_dec = after_inc;
    if (fell[BTN_DEC] && after_inc.editing) begin
      case (after_inc.index) inside
        IDX_HOUR_TENS: after_dec.hours = 5'(wrap_sub(h6, 6'd10, 6'd23));
        IDX_HOUR_ONES: after_dec.hours = 5'(wrap_sub(h6, 6'd1, 6'd23));
        IDX_MIN_TENS:  after_dec.minutes = wrap_sub(after_inc.minutes, 6'd10, 6'd59);
        IDX_MIN_ONES:  after_dec.minutes = wrap_sub(after_inc.minutes, 6'd1, 6'd59);
        IDX_SEC_TENS:  after_dec.seconds = wrap_sub(after_inc.seconds, 6'd10, 6'd59);
        IDX_SEC_ONES:  after_dec.seconds = wrap_sub(after_inc.seconds, 6'd1, 6'd59);
        IDX_DAY_A, IDX_DAY_B:
          after_dec.day = (after_inc.day > 5'd1) ? after_inc.day - 5'd1 : 5'd31;
        IDX_MONTH_A, IDX_MONTH_B:
          after_dec.month = (after_inc.month > 4'd1) ? after_inc.month - 4'd1 : 4'd12;
        IDX_YEAR:
          if (after_inc.year > min_year) after_dec.year = after_inc.year - 14'd1;
        default: ;
      endcase
    end
  end

  always_comb begin
    nxt = after_dec;
    if (fell[BTN_SAVE]) begin
      nxt.editing = 1'b0;
    end
  end

endmodule

[sv/csbe_out_queue.sv]
module csbe_out_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  csbe_pkg::csbe_clock_t      push_data,
  input  logic                       out_stall,
  output logic                       out_valid,
  output csbe_pkg::csbe_clock_t      out_data,
  output csbe_pkg::csbe_queue_stat_t stat
);
  import csbe_pkg::*;

  logic        main_valid;
  logic        skid_valid;
  csbe_clock_t main_data;
  csbe_clock_t skid_data;
  logic        pop;

  assign pop = main_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid) begin
      main_valid <= push;
      main_data  <= push_data;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= push;
        skid_data  <= push_data;
      end else begin
        main_valid <= push;
        main_data  <= push_data;
      end
    end else if (push) begin
      // caller only pushes here while the skid slot is free
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  assign out_valid       = main_valid;
  assign out_data        = main_data;
  assign stat.main_valid = main_valid;
  assign stat.skid_valid = skid_valid;

endmodule

[sv/clock_setting_button_editor.sv]
// Clock time/date setting editor, four active-low buttons per poll.
// Each poll is held in the input register, then one pass of edit logic
// writes its result into the result queue, which drives the outputs.
// Throughput: one poll per cycle while the two-entry result queue is not full; a full queue stalls the poll channel.
// Reset (rst, synchronous): not editing, index 0, 12:00:00, day 1, month 1,
// year 2025, all buttons released, min_year 2000.
module clock_setting_button_editor (
  input  logic                          clk,
  input  logic                          rst,
  // poll channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          set_level,
  input  logic                          inc_level,
  input  logic                          dec_level,
  input  logic                          save_level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          editing,
  output logic [csbe_pkg::INDEX_W-1:0]  field_index,
  output logic [4:0]                    hours,
  output logic [5:0]                    minutes,
  output logic [5:0]                    seconds,
  output logic [4:0]                    day_of_month,
  output logic [3:0]                    month_number,
  output logic [csbe_pkg::YEAR_W-1:0]   year_number,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import csbe_pkg::*;

  // register file
  logic [YEAR_W-1:0] min_year;

  // input register: one poll waiting for the edit pass
  logic       poll_valid;
  logic [3:0] poll_levels;

  // editor state
  logic [3:0]  prev_levels;
  csbe_clock_t clk_state;
  csbe_clock_t clk_state_next;

  csbe_queue_stat_t q_stat;
  csbe_clock_t      result;
  logic             queue_full;
  logic             pop;
  logic             process;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_MIN_YEAR) begin
      min_year <= pwdata[YEAR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ADDR_MIN_YEAR) begin
      prdata = {{(32-YEAR_W){1'b0}}, min_year};
    end
  end

  // The edit pass may run when the queue has a free slot or drains this cycle.
  assign queue_full = q_stat.main_valid && q_stat.skid_valid;
  assign pop        = q_stat.main_valid && !out_stall;
  assign process    = poll_valid && (!queue_full || pop);

  // Stall only from registers; when not stalled the poll register is free
  // (either empty or being processed this cycle).
  assign in_stall = poll_valid && queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      poll_valid  <= 1'b1;
      poll_levels <= {save_level, dec_level, inc_level, set_level};
    end else if (process) begin
      poll_valid <= 1'b0;
    end
  end

  csbe_field_step u_step (
    .cur         (clk_state),
    .prev_levels (prev_levels),
    .now_levels  (poll_levels),
    .min_year    (min_year),
    .nxt         (clk_state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels       <= 4'b1111;
      clk_state.editing <= 1'b0;
      clk_state.index   <= IDX_HOUR_TENS;
      clk_state.hours   <= HOUR_RESET;
      clk_state.minutes <= '0;
      clk_state.seconds <= '0;
      clk_state.day     <= 5'd1;
      clk_state.month   <= 4'd1;
      clk_state.year    <= YEAR_RESET;
    end else if (process) begin
      prev_levels <= poll_levels;
      clk_state   <= clk_state_next;
    end
  end

  csbe_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (process),
    .push_data (clk_state_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (result),
    .stat      (q_stat)
  );

  assign editing      = result.editing;
  assign field_index  = result.index;
  assign hours        = result.hours;
  assign minutes      = result.minutes;
  assign seconds      = result.seconds;
  assign day_of_month = result.day;
  assign month_number = result.month;
  assign year_number  = result.year;

endmodule

[test/tb.sv]
module tb;
  import csbe_pkg::*;

  // Cycles with no transfer on either channel before the run is called hung.
  localparam int unsigned QUIET_LIMIT = 500;
  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int unsigned PRINT_CAP   = 100;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 set_level;
  logic                 inc_level;
  logic                 dec_level;
  logic                 save_level;
  logic                 out_valid;
  logic                 out_stall;
  logic                 editing;
  logic [INDEX_W-1:0]   field_index;
  logic [4:0]           hours;
  logic [5:0]           minutes;
  logic [5:0]           seconds;
  logic [4:0]           day_of_month;
  logic [3:0]           month_number;
  logic [YEAR_W-1:0]    year_number;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  clock_setting_button_editor dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .set_level    (set_level),
    .inc_level    (inc_level),
    .dec_level    (dec_level),
    .save_level   (save_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .editing      (editing),
    .field_index  (field_index),
    .hours        (hours),
    .minutes      (minutes),
    .seconds      (seconds),
    .day_of_month (day_of_month),
    .month_number (month_number),
    .year_number  (year_number),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------
  // Shadow of the editor: button history, mode, index, clock/date fields
  // and the min_year register, all at the block's widths.
  // ---------------------------------------------------------------------
  logic [3:0]          last_levels;
  logic                edit_on;
  logic [INDEX_W-1:0]  sel_idx;
  logic [4:0]          hr;
  logic [5:0]          mn;
  logic [5:0]          sc;
  logic [4:0]          dy;
  logic [3:0]          mo;
  logic [YEAR_W-1:0]   yr;
  logic [YEAR_W-1:0]   min_yr;

  csbe_clock_t         clock_q[$];   // predicted clock state, one per poll
  int unsigned         err_cnt;
  int unsigned         polls_sent;
  int unsigned         quiet_cycles;
  bit                  gaps_on;      // random idling on both channels

  // Modular step up; a tens step wraps by the same modulus.
  function automatic int unsigned add_wrap(int unsigned v, int unsigned by,
                                           int unsigned modulus);
    return (v + by) % modulus;
  endfunction

  // Step down; going below zero lands on the top value, not modulo.
  function automatic int unsigned sub_wrap(int unsigned v, int unsigned by,
                                           int unsigned top);
    return (v >= by) ? v - by : top;
  endfunction

  function automatic void bump_field(bit up);
    case (sel_idx)
      IDX_HOUR_TENS: hr = 5'(up ? add_wrap(hr, 10, 24) : sub_wrap(hr, 10, 23));
      IDX_HOUR_ONES: hr = 5'(up ? add_wrap(hr, 1, 24)  : sub_wrap(hr, 1, 23));
      IDX_MIN_TENS:  mn = 6'(up ? add_wrap(mn, 10, 60) : sub_wrap(mn, 10, 59));
      IDX_MIN_ONES:  mn = 6'(up ? add_wrap(mn, 1, 60)  : sub_wrap(mn, 1, 59));
      IDX_SEC_TENS:  sc = 6'(up ? add_wrap(sc, 10, 60) : sub_wrap(sc, 10, 59));
      IDX_SEC_ONES:  sc = 6'(up ? add_wrap(sc, 1, 60)  : sub_wrap(sc, 1, 59));
      IDX_DAY_A, IDX_DAY_B:
        dy = up ? ((dy == 5'd31) ? 5'd1 : dy + 5'd1)
                : ((dy > 5'd1) ? dy - 5'd1 : 5'd31);
      IDX_MONTH_A, IDX_MONTH_B:
        mo = up ? ((mo == 4'd12) ? 4'd1 : mo + 4'd1)
                : ((mo > 4'd1) ? mo - 4'd1 : 4'd12);
      IDX_YEAR: begin
        // year saturates at the top, and never drops below min_year
        if (up && yr < YEAR_MAX) yr = yr + 14'd1;
        if (!up && yr > min_yr) yr = yr - 14'd1;
      end
      default: ;
    endcase
  endfunction

  // Apply one poll to the shadow; returns the state the block should show.
  function automatic csbe_clock_t next_clock(logic [3:0] levels);
    logic [3:0]  fell;
    csbe_clock_t r;
    fell = last_levels & ~levels;
    // edges handled in order set, inc, dec, save; each sees the one before
    if (fell[BTN_SET]) begin
      if (!edit_on) begin
        edit_on = 1'b1;
        sel_idx = IDX_HOUR_TENS;
      end else if (sel_idx < IDX_LAST) begin
        sel_idx = sel_idx + 4'd1;
      end
    end
    if (fell[BTN_INC] && edit_on) bump_field(1'b1);
    if (fell[BTN_DEC] && edit_on) bump_field(1'b0);
    if (fell[BTN_SAVE]) edit_on = 1'b0;
    last_levels = levels;
    r.editing = edit_on;
    r.index   = sel_idx;
    r.hours   = hr;
    r.minutes = mn;
    r.seconds = sc;
    r.day     = dy;
    r.month   = mo;
    r.year    = yr;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset, input defaults
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    set_level  = 1'b1;
    inc_level  = 1'b1;
    dec_level  = 1'b1;
    save_level = 1'b1;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
  end

  // Receiver backpressure, changed on the falling edge like every input.
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 29);
  end

  // ---------------------------------------------------------------------
  // Result checking: each result transfer against the oldest prediction.
  // ---------------------------------------------------------------------
  task automatic report(string msg);
    if (err_cnt < PRINT_CAP) $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    csbe_clock_t want;
    if (!rst && out_valid && !out_stall) begin
      if (clock_q.size() == 0) begin
        report("result transfer with no poll outstanding");
      end else begin
        want = clock_q.pop_front();
        check_field("editing",      editing,      want.editing);
        check_field("field_index",  field_index,  want.index);
        check_field("hours",        hours,        want.hours);
        check_field("minutes",      minutes,      want.minutes);
        check_field("seconds",      seconds,      want.seconds);
        check_field("day_of_month", day_of_month, want.day);
        check_field("month_number", month_number, want.month);
        check_field("year_number",  year_number,  want.year);
      end
    end
  end

  // Watchdog: too long without any transfer means the block is hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, clock_q.size());
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------

  // One poll: optional idle cycles, then hold the levels until transferred.
  task automatic send_poll(logic [3:0] levels);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    set_level  <= levels[BTN_SET];
    inc_level  <= levels[BTN_INC];
    dec_level  <= levels[BTN_DEC];
    save_level <= levels[BTN_SAVE];
    do @(posedge clk); while (in_stall);
    clock_q.push_back(next_clock(levels));
    polls_sent++;
    @(negedge clk);
  endtask

  // Press the buttons in mask for hold polls, then release everything.
  task automatic tap(logic [3:0] mask, int unsigned hold = 1);
    repeat (hold) send_poll(~mask);
    send_poll(4'hF);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (clock_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);   // covers the input register and the result queue
  endtask

  // Register write, setup then access phase; only called with nothing in flight.
  task automatic write_min_year(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ADDR_MIN_YEAR, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    min_yr = value[YEAR_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  localparam logic [3:0] M_SET  = 4'b1 << BTN_SET;
  localparam logic [3:0] M_INC  = 4'b1 << BTN_INC;
  localparam logic [3:0] M_DEC  = 4'b1 << BTN_DEC;
  localparam logic [3:0] M_SAVE = 4'b1 << BTN_SAVE;

  // Enter edit mode (leaving first if needed) and walk to the year field,
  // one set edge beyond it so the index saturates.
  task automatic go_to_year();
    tap(M_SAVE);
    repeat (int'(IDX_LAST) + 2) tap(M_SET);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Directed: ignored buttons outside edit mode, held set, simultaneous
  // edges and the hour wraps.
  task automatic test_directed();
    send_poll(4'hF);
    tap(M_INC);                       // not editing: ignored
    tap(M_SAVE);                      // not editing: mode unchanged
    tap(M_SET, 2);                    // enter edit; held set does not repeat
    tap(M_INC);                       // 12 -> 22
    tap(M_INC | M_DEC);               // 22 -> 8 -> 23
    tap(M_SET | M_INC | M_DEC | M_SAVE); // idx 1, 23 -> 0 -> 23, then leave
    tap(M_INC);                       // not editing again: ignored
    tap(M_SET);                       // re-enter at index 0
    repeat (3) tap(M_DEC);            // 23 -> 13 -> 3 -> 23
    tap(M_SAVE);
  endtask

  // Mostly well-formed edit sessions with random content, some raw noise.
  task automatic run_random(int unsigned n_polls);
    int unsigned first;
    int unsigned target;
    int unsigned n_ops;
    int unsigned pick;
    bit          paused;
    first  = polls_sent;
    paused = 1'b0;
    while (polls_sent - first < n_polls) begin
      if (!paused && polls_sent - first >= n_polls / 2) begin
        drain_results();              // sender holds off until all results land
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) begin
        target = $urandom_range(0, int'(IDX_LAST) + 2);
        n_ops  = $urandom_range(1, 8);
        repeat (target + 1) tap(M_SET, $urandom_range(1, 2));
        repeat (n_ops) begin
          pick = $urandom_range(0, 99);
          if (pick < 45)      tap(M_INC, $urandom_range(1, 2));
          else if (pick < 90) tap(M_DEC, $urandom_range(1, 2));
          else                tap(M_INC | M_DEC);
        end
        if ($urandom_range(0, 3) != 0) tap(M_SAVE);
      end else begin
        repeat ($urandom_range(1, 6)) send_poll(4'($urandom_range(0, 15)));
      end
    end
  endtask

  // Year floor at min_year, a min_year above the current year and one above
  // the year range.
  task automatic test_year_limits();
    drain_results();
    write_min_year(32'd2023);
    go_to_year();
    while (yr > min_yr) tap(M_DEC);
    tap(M_DEC);                       // at the floor: blocked
    repeat (20) tap(M_INC);
    tap(M_SAVE);
    drain_results();
    write_min_year(32'(YEAR_MAX));
    go_to_year();
    tap(M_DEC);                       // year below min_year: blocked
    drain_results();
    write_min_year(32'h3FFF);         // above the year range
    tap(M_DEC);
    tap(M_INC);
    drain_results();
    write_min_year(32'd0);
    repeat (3) tap(M_DEC);
    tap(M_SAVE);
    drain_results();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    err_cnt      = 0;
    polls_sent   = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b1;
    last_levels  = 4'hF;
    edit_on      = 1'b0;
    sel_idx      = IDX_HOUR_TENS;
    hr           = HOUR_RESET;
    mn           = '0;
    sc           = '0;
    dy           = 5'd1;
    mo           = 4'd1;
    yr           = YEAR_RESET;
    min_yr       = MIN_YEAR_RESET;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    run_random(180);                  // reset min_year

    drain_results();
    write_min_year(32'd2023);
    gaps_on = 1'b0;                   // long stretch at full rate both sides
    run_random(120);
    gaps_on = 1'b1;

    test_year_limits();
    run_random(200);                  // min_year 0

    drain_results();
    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
